// ----- rtl/budgeted_priority_tx_queue_assert.svh -----
// ----------------------------------------------------------------------------
// budgeted priority tx queue assertion macros
// clocked assertion shorthands used by the checker file bprq_chk
// ----------------------------------------------------------------------------
`ifndef BUDGETED_PRIORITY_TX_QUEUE_ASSERT_SVH
`define BUDGETED_PRIORITY_TX_QUEUE_ASSERT_SVH

// checked outside reset only
`define BPRQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define BPRQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/bprq_pkg.sv -----
// ----------------------------------------------------------------------------
// bprq_pkg
// shared sizes, codes, types and helpers of the budgeted priority tx queue
// ----------------------------------------------------------------------------
package bprq_pkg;

   localparam int MAX_PRIORITIES = 8;
   localparam int QUEUE_DEPTH    = 16;

   localparam int PRIO_W      = $clog2(MAX_PRIORITIES);
   localparam int PCNT_W      = $clog2(MAX_PRIORITIES + 1);
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int STORE_DEPTH = MAX_PRIORITIES * QUEUE_DEPTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int BUDGET_W    = 24;
   localparam int TOTAL_W     = BUDGET_W + PRIO_W;
   localparam int WORD_W      = 32;

   localparam logic [BUDGET_W-1:0] RESET_ROUND_BUDGET = 24'd12500;
   localparam logic [3:0]          RESET_PRIO_COUNT   = 4'd8;
   localparam logic [2:0]          DEFAULT_PRIORITY   = 3'd2;
   localparam logic [7:0]          PERCENT_FULL       = 8'd100;

   // request kinds
   localparam logic [1:0] REQ_ENQUEUE = 2'd0;
   localparam logic [1:0] REQ_DEQUEUE = 2'd1;
   localparam logic [1:0] REQ_REMOVE  = 2'd2;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   // result status codes
   localparam logic [2:0] ST_ENQUEUED    = 3'd0;
   localparam logic [2:0] ST_RETURNED    = 3'd1;
   localparam logic [2:0] ST_NOTHING     = 3'd2;
   localparam logic [2:0] ST_ROUND_RESET = 3'd3;
   localparam logic [2:0] ST_QUEUE_FULL  = 3'd4;
   localparam logic [2:0] ST_BAD_PRIO    = 3'd5;

   // register indexes
   localparam logic [1:0] CSR_ROUND_BUDGET = 2'd0;
   localparam logic [1:0] CSR_PRIO_COUNT   = 2'd1;
   localparam logic [1:0] CSR_SHARE_LOW    = 2'd2;
   localparam logic [1:0] CSR_SHARE_HIGH   = 2'd3;

   // datapath commands
   typedef logic [3:0] cmd_code_type;
   localparam cmd_code_type CMD_NONE        = 4'd0;
   localparam cmd_code_type CMD_ENQ         = 4'd1;
   localparam cmd_code_type CMD_NONE_ELIG   = 4'd2;
   localparam cmd_code_type CMD_ROUND_RESET = 4'd3;
   localparam cmd_code_type CMD_SCAN_START  = 4'd4;
   localparam cmd_code_type CMD_NEXT        = 4'd5;
   localparam cmd_code_type CMD_READ        = 4'd6;
   localparam cmd_code_type CMD_POP_SEND    = 4'd7;
   localparam cmd_code_type CMD_RM_READ     = 4'd8;
   localparam cmd_code_type CMD_POP_RM      = 4'd9;
   localparam cmd_code_type CMD_LOAD        = 4'd10;

   typedef struct packed {
      cmd_code_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic       req_valid;
      logic [1:0] req_type;
      logic       total_ge_budget;
      logic       scan_end;
      logic       scan_empty;
      logic       fits;
      logic       rm_found;
      logic       out_free;
   } dp_status_type;

   // saturated percent of one priority, zero beyond the register bytes
   function automatic logic [6:0] share_pct(input logic [31:0] lo, input logic [31:0] hi,
                                            input logic [PCNT_W-1:0] p);
      logic [63:0] both;
      logic [7:0]  pct;
      both = {hi, lo};
      pct  = 8'd0;
      for (int i = 0; i < 8; i++) begin
         if (int'(p) == i) begin
            pct = both[8*i +: 8];
         end
      end
      return (pct > PERCENT_FULL) ? PERCENT_FULL[6:0] : pct[6:0];
   endfunction

   function automatic logic [ADDR_W-1:0] store_addr(input logic [PRIO_W-1:0] idx,
                                                    input logic [QPTR_W-1:0] ptr);
      return ADDR_W'(int'(idx) * QUEUE_DEPTH + int'(ptr));
   endfunction

   function automatic logic [QPTR_W-1:0] advance(input logic [QPTR_W-1:0] ptr);
      return (int'(ptr) >= QUEUE_DEPTH - 1) ? '0 : QPTR_W'(int'(ptr) + 1);
   endfunction

endpackage

// ----- rtl/bprq_ram.sv -----
// ----------------------------------------------------------------------------
// bprq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bprq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/bprq_dp.sv -----
// ----------------------------------------------------------------------------
// bprq_dp
// datapath: config registers, fifo pointers, byte counters, store and result
// ----------------------------------------------------------------------------
module bprq_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_wdata,
   input  logic                   req_tvalid,
   input  logic                   req_accept,
   input  logic [1:0]             req_tuser,
   input  logic [39:0]            req_tdata,
   input  bprq_pkg::dp_cmd_type   cmd,
   output bprq_pkg::dp_status_type sts,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [2:0]             rsp_tuser,
   output logic [39:0]            rsp_tdata
);
   import bprq_pkg::*;

   logic [BUDGET_W-1:0] budget_ff;
   logic [3:0]          pcount_ff;
   logic [31:0]         pct_lo_ff;
   logic [31:0]         pct_hi_ff;

   logic [QPTR_W-1:0]   head_ff  [MAX_PRIORITIES];
   logic [QPTR_W-1:0]   tail_ff  [MAX_PRIORITIES];
   logic [QCNT_W-1:0]   qcnt_ff  [MAX_PRIORITIES];
   logic [BUDGET_W-1:0] bytes_ff [MAX_PRIORITIES];
   logic [TOTAL_W-1:0]  total_ff;

   logic [2:0]          prio_ff;
   logic [WORD_W-1:0]   word_ff;
   logic [PCNT_W-1:0]   cur_p_ff;
   logic [30:0]         share_prod_ff;

   logic [2:0]          res_status_ff;
   logic [WORD_W-1:0]   res_word_ff;
   logic [2:0]          res_prio_ff;
   logic                rsp_valid_ff;
   logic [2:0]          rsp_status_ff;
   logic [WORD_W-1:0]   rsp_word_ff;
   logic [2:0]          rsp_prio_ff;

   logic [PCNT_W-1:0]   count_eff;
   logic [PRIO_W-1:0]   enq_idx;
   logic [PRIO_W-1:0]   cur_idx;
   logic [PRIO_W-1:0]   rm_idx;
   logic [PCNT_W-1:0]   rm_p;
   logic                rm_found;
   logic                enq_bad;
   logic                enq_full;
   logic                enq_ok;
   logic                clear_cnt;
   logic [15:0]         head_len;
   logic [15:0]         len_min1;
   logic [BUDGET_W:0]   need_sum;
   logic [31:0]         need_scaled;
   logic                ram_we;
   logic                ram_re;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [WORD_W-1:0]   ram_rdata;

   always_comb begin
      if (int'(pcount_ff) > MAX_PRIORITIES) begin
         count_eff = PCNT_W'(MAX_PRIORITIES);
      end else begin
         count_eff = PCNT_W'(pcount_ff);
      end
   end

   assign enq_idx  = PRIO_W'(prio_ff);
   assign cur_idx  = cur_p_ff[PRIO_W-1:0];
   assign enq_bad  = int'(prio_ff) >= int'(count_eff);
   assign enq_full = int'(qcnt_ff[enq_idx]) >= QUEUE_DEPTH;
   assign enq_ok   = !enq_bad && !enq_full;

   // most urgent non-empty fifo below the count
   always_comb begin
      rm_found = 1'b0;
      rm_p     = '0;
      for (int i = MAX_PRIORITIES - 1; i >= 0; i--) begin
         if (i < int'(count_eff) && qcnt_ff[i] != '0) begin
            rm_found = 1'b1;
            rm_p     = PCNT_W'(i);
         end
      end
   end
   assign rm_idx = rm_p[PRIO_W-1:0];

   // head fits when 100 * (sent + max(len, 1)) <= pct * budget
   assign head_len    = ram_rdata[15:0];
   assign len_min1    = (head_len == 16'd0) ? 16'd1 : head_len;
   assign need_sum    = {1'b0, bytes_ff[cur_idx]} + (BUDGET_W+1)'(len_min1);
   assign need_scaled = 32'(need_sum) * 32'd100;

   assign ram_we    = (cmd.op == CMD_ENQ) && enq_ok;
   assign ram_waddr = store_addr(enq_idx, tail_ff[enq_idx]);
   assign ram_re    = (cmd.op == CMD_READ) || (cmd.op == CMD_RM_READ);
   assign ram_raddr = (cmd.op == CMD_RM_READ) ? store_addr(rm_idx, head_ff[rm_idx])
                                              : store_addr(cur_idx, head_ff[cur_idx]);

   bprq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (word_ff),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= RESET_ROUND_BUDGET;
         pcount_ff <= RESET_PRIO_COUNT;
         pct_lo_ff <= '0;
         pct_hi_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROUND_BUDGET: budget_ff <= csr_wdata[BUDGET_W-1:0];
            CSR_PRIO_COUNT:   pcount_ff <= csr_wdata[3:0];
            CSR_SHARE_LOW:    pct_lo_ff <= csr_wdata;
            CSR_SHARE_HIGH:   pct_hi_ff <= csr_wdata;
            default:          pcount_ff <= pcount_ff;
         endcase
      end
   end

   assign clear_cnt = csr_we || (cmd.op == CMD_ROUND_RESET);

   always_ff @(posedge clock) begin
      if (reset || clear_cnt) begin
         for (int i = 0; i < MAX_PRIORITIES; i++) begin
            bytes_ff[i] <= '0;
         end
         total_ff <= '0;
      end else if (cmd.op == CMD_POP_SEND) begin
         bytes_ff[cur_idx] <= bytes_ff[cur_idx] + BUDGET_W'(head_len);
         total_ff          <= total_ff + TOTAL_W'(head_len);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PRIORITIES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            qcnt_ff[i] <= '0;
         end
      end else if (ram_we) begin
         tail_ff[enq_idx] <= advance(tail_ff[enq_idx]);
         qcnt_ff[enq_idx] <= qcnt_ff[enq_idx] + QCNT_W'(1);
      end else if (cmd.op == CMD_POP_SEND || cmd.op == CMD_POP_RM) begin
         head_ff[cur_idx] <= advance(head_ff[cur_idx]);
         qcnt_ff[cur_idx] <= qcnt_ff[cur_idx] - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         prio_ff <= req_tdata[0] ? req_tdata[3:1] : DEFAULT_PRIORITY;
         word_ff <= {req_tdata[19:4], req_tdata[35:20]};
      end
      case (cmd.op)
         CMD_SCAN_START: cur_p_ff <= '0;
         CMD_NEXT:       cur_p_ff <= cur_p_ff + PCNT_W'(1);
         CMD_RM_READ:    cur_p_ff <= rm_p;
         default:        cur_p_ff <= cur_p_ff;
      endcase
      if (cmd.op == CMD_READ) begin
         share_prod_ff <= 31'(share_pct(pct_lo_ff, pct_hi_ff, cur_p_ff)) * 31'(budget_ff);
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         CMD_ENQ: begin
            res_status_ff <= enq_bad ? ST_BAD_PRIO : (enq_full ? ST_QUEUE_FULL : ST_ENQUEUED);
            res_word_ff   <= '0;
            res_prio_ff   <= prio_ff;
         end
         CMD_NONE_ELIG: begin
            res_status_ff <= ST_NOTHING;
            res_word_ff   <= '0;
            res_prio_ff   <= '0;
         end
         CMD_ROUND_RESET: begin
            res_status_ff <= ST_ROUND_RESET;
            res_word_ff   <= '0;
            res_prio_ff   <= '0;
         end
         CMD_POP_SEND, CMD_POP_RM: begin
            res_status_ff <= ST_RETURNED;
            res_word_ff   <= ram_rdata;
            res_prio_ff   <= 3'(cur_p_ff);
         end
         default: res_status_ff <= res_status_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == CMD_LOAD) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == CMD_LOAD) begin
         rsp_status_ff <= res_status_ff;
         rsp_word_ff   <= res_word_ff;
         rsp_prio_ff   <= res_prio_ff;
      end
   end

   assign sts.req_valid       = req_tvalid;
   assign sts.req_type        = req_tuser;
   assign sts.total_ge_budget = total_ff >= TOTAL_W'(budget_ff);
   assign sts.scan_end        = cur_p_ff >= count_eff;
   assign sts.scan_empty      = qcnt_ff[cur_idx] == '0;
   assign sts.fits            = need_scaled <= {1'b0, share_prod_ff};
   assign sts.rm_found        = rm_found;
   assign sts.out_free        = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {5'd0, rsp_prio_ff, rsp_word_ff[15:0], rsp_word_ff[31:16]};

endmodule

// ----- rtl/bprq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bprq_ctrl
// controller: sequences enqueue, budgeted scan, remove and result hand-off
// ----------------------------------------------------------------------------
module bprq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   output logic                    req_tready,
   input  bprq_pkg::dp_status_type sts,
   output bprq_pkg::dp_cmd_type    cmd
);
   import bprq_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ENQ  = 4'd1;
   localparam logic [3:0] S_NONE = 4'd2;
   localparam logic [3:0] S_DQ   = 4'd3;
   localparam logic [3:0] S_RD   = 4'd4;
   localparam logic [3:0] S_CMP  = 4'd5;
   localparam logic [3:0] S_RM   = 4'd6;
   localparam logic [3:0] S_RMD  = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (sts.req_valid) begin
               case (sts.req_type)
                  REQ_ENQUEUE: state_in = S_ENQ;
                  REQ_DEQUEUE: state_in = S_DQ;
                  REQ_REMOVE:  state_in = S_RM;
                  default:     state_in = S_NONE;
               endcase
            end
         end
         S_ENQ: begin
            cmd.op   = CMD_ENQ;
            state_in = S_OUT;
         end
         S_NONE: begin
            cmd.op   = CMD_NONE_ELIG;
            state_in = S_OUT;
         end
         S_DQ: begin
            if (sts.total_ge_budget) begin
               cmd.op   = CMD_ROUND_RESET;
               state_in = S_OUT;
            end else begin
               cmd.op   = CMD_SCAN_START;
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (sts.scan_end) begin
               cmd.op   = CMD_NONE_ELIG;
               state_in = S_OUT;
            end else if (sts.scan_empty) begin
               cmd.op = CMD_NEXT;
            end else begin
               cmd.op   = CMD_READ;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (sts.fits) begin
               cmd.op   = CMD_POP_SEND;
               state_in = S_OUT;
            end else begin
               cmd.op   = CMD_NEXT;
               state_in = S_RD;
            end
         end
         S_RM: begin
            if (sts.rm_found) begin
               cmd.op   = CMD_RM_READ;
               state_in = S_RMD;
            end else begin
               cmd.op   = CMD_NONE_ELIG;
               state_in = S_OUT;
            end
         end
         S_RMD: begin
            cmd.op   = CMD_POP_RM;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.op   = CMD_LOAD;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/budgeted_priority_tx_queue.sv -----
// enqueue and unknown requests: S_ENQ or S_NONE writes the result, S_OUT sets it valid
// remove: S_RM, S_RMD for the registered ram read (skipped when no fifo holds an item), S_OUT
// budgeted dequeue: S_DQ, then S_RD per priority, S_CMP for each non-empty one read and
//   compared (empty ones skipped in S_RD), then S_OUT; round reset goes S_DQ to S_OUT
// one item in flight, no accept until the result is loaded; a held result stalls it
// reset (synchronous): fifos empty, counters zero, registers at defaults, no clearing pass
// ----------------------------------------------------------------------------
// budgeted_priority_tx_queue
// strict priority descriptor queue with per priority byte shares per round
// ----------------------------------------------------------------------------
module budgeted_priority_tx_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,  // req_type
   input  logic [39:0] req_tdata,  // tag_present, tag_priority, pkt_handle, pkt_length
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,  // status
   output logic [39:0] rsp_tdata   // out_handle, out_length, out_priority
);
   import bprq_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type sts;
   logic          req_accept;

   assign req_accept = req_tvalid && req_tready;

   bprq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bprq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_accept (req_accept),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/bprq_chk.sv -----
// ----------------------------------------------------------------------------
// bprq_chk
// port level checks of the budgeted priority tx queue, bound to the top
// ----------------------------------------------------------------------------
`include "budgeted_priority_tx_queue_assert.svh"

module bprq_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [2:0]  rsp_tuser,
   input logic [39:0] rsp_tdata
);
   import bprq_pkg::*;

   `BPRQ_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `BPRQ_ASSERT(a_busy_after_accept, req_tvalid && req_tready |=> !req_tready, "item taken while busy")
   `BPRQ_ASSERT(a_status_range, rsp_tvalid |-> rsp_tuser <= ST_BAD_PRIO, "status code out of range")
   `BPRQ_ASSERT(a_zero_payload, rsp_tvalid && rsp_tuser != ST_RETURNED |-> rsp_tdata[31:0] == 32'd0, "payload set without a packet")
   `BPRQ_ASSERT_ALWAYS(a_reset_state, reset |=> !rsp_tvalid && req_tready, "reset left block busy")

endmodule

bind budgeted_priority_tx_queue bprq_chk u_chk (.*);
